@@ sv/sa_pkg.sv @@
// segment allocator package: widths, status and op codes, register map
// no dependencies
package sa_pkg;
  localparam int TotalUnits  = 128;
  localparam int MaxSegments = 128;
  localparam int IdWidth     = 16;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_DECLINED = 2'd1,
    ST_NO_OWNER = 2'd2
  } status_e;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] REG_FIT_MODE = 2'd0;
endpackage

@@ sv/segment_allocator_first_best_fit.sv @@
// segment allocator, first fit or best fit, top level
// depends on sa_pkg and sa_ram
//
// usage: one request beat on the s_axis side (tdata = op, owner_id, units_wanted),
// one result beat on the m_axis side (tdata = status, visited_count,
// small_fragments). fit_mode is written over the apb port at address 0.
// the table of segments lives in one ram, one entry a word (size, owner,
// free), accessed at one address per cycle by a small sequencer.
// an allocate walks the table (each entry: address, then read), then
// shifts the tail up one place and writes the split. a free walks until
// the owner is found. every request ends with a counting pass over the
// table for small fragments. s_axis_tready is low while a request is in
// work. the result sits in an output register; a stalled receiver holds
// the block until the beat is taken, the next request is accepted
// afterwards.
// reset: the table holds one free segment of TOTAL_UNITS units; entry 0 is
// written in the S_INIT state entered at reset (tready low then), entries beyond
// the count are never used so no further clearing is needed.
module segment_allocator_first_best_fit #(
  parameter int TOTAL_UNITS  = sa_pkg::TotalUnits,
  parameter int MAX_SEGMENTS = sa_pkg::MaxSegments
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // op [0], owner_id [16:1], units_wanted [24:17], zero fill to 32
  input  logic [31:0] s_axis_tdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // status [1:0], visited_count [9:2], small_fragments [17:10], zero fill to 24
  output logic [23:0] m_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import sa_pkg::*;

  localparam int AW = $clog2(MAX_SEGMENTS);
  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam int WW = 8 + IdWidth + 1;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SRD    = 4'd1;
  localparam logic [3:0] S_SCHK   = 4'd2;
  localparam logic [3:0] S_MRD    = 4'd3;
  localparam logic [3:0] S_MWR    = 4'd4;
  localparam logic [3:0] S_PRD    = 4'd5;
  localparam logic [3:0] S_PWR    = 4'd6;
  localparam logic [3:0] S_CRD    = 4'd7;
  localparam logic [3:0] S_CCHK   = 4'd8;
  localparam logic [3:0] S_OUT    = 4'd9;
  localparam logic [3:0] S_INIT   = 4'd10;

  logic [3:0] state_q, state_d;
  logic       fit_mode_q;
  logic [CW-1:0] count_q, count_d, idx_q, idx_d, pick_q, pick_d;
  logic [7:0] best_q, best_d, small_q, small_d, visited_q, visited_d;
  logic       found_q, found_d;
  logic [1:0] status_q, status_d;
  logic       op_q;
  logic [IdWidth-1:0] owner_q;
  logic [7:0] units_q;

  logic          we;
  logic [AW-1:0] addr;
  logic [WW-1:0] wdata, rdata;
  logic [7:0]    r_size;
  logic [IdWidth-1:0] r_owner;
  logic          r_free;
  logic          cfg_wr;

  assign {r_size, r_owner, r_free} = rdata;

  sa_ram #(.Width(WW), .Depth(MAX_SEGMENTS)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .addr_i (addr),
    .wdata_i(wdata),
    .rdata_o(rdata)
  );

  // apb register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == REG_FIT_MODE);
  assign prdata = (paddr == REG_FIT_MODE) ? {31'd0, fit_mode_q} : 32'd0;

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = (state_q == S_OUT);
  assign m_axis_tdata  = {6'd0, small_q, visited_q, status_q};

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    idx_d     = idx_q;
    pick_d    = pick_q;
    best_d    = best_q;
    small_d   = small_q;
    visited_d = visited_q;
    found_d   = found_q;
    status_d  = status_q;
    we        = 1'b0;
    addr      = idx_q[AW-1:0];
    wdata     = '0;
    unique case (state_q)
      S_INIT: begin
        // reset image of entry 0: one free segment of all units
        we      = 1'b1;
        wdata   = {8'(TOTAL_UNITS), IdWidth'(0), 1'b1};
        state_d = S_IDLE;
      end
      S_IDLE: begin
        idx_d     = '0;
        found_d   = 1'b0;
        visited_d = '0;
        small_d   = '0;
        if (s_axis_tvalid) begin
          status_d = (s_axis_tdata[0] == OP_FREE) ? ST_NO_OWNER : ST_OK;
          if (s_axis_tdata[0] == OP_ALLOC && (s_axis_tdata[IdWidth+8:IdWidth+1] == 8'd0
              || count_q == CW'(MAX_SEGMENTS))) begin
            status_d = ST_DECLINED;
            state_d  = S_CRD;
          end else begin
            state_d = S_SRD;
          end
        end
      end
      S_SRD: begin
        // address issued, read lands next cycle
        if (idx_q == count_q) begin
          if (op_q == OP_FREE || !found_q) begin
            if (op_q == OP_ALLOC) status_d = ST_DECLINED;
            idx_d   = '0;
            state_d = S_CRD;
          end else begin
            visited_d = 8'(count_q);
            idx_d     = count_q;
            state_d   = S_MRD;
          end
        end else begin
          state_d = S_SCHK;
        end
      end
      S_SCHK: begin
        idx_d   = idx_q + 1'b1;
        state_d = S_SRD;
        if (op_q == OP_FREE) begin
          if (!r_free && r_owner == owner_q) begin
            we       = 1'b1;
            wdata    = {r_size, r_owner, 1'b1};
            status_d = ST_OK;
            idx_d    = '0;
            state_d  = S_CRD;
          end
        end else if (r_free && r_size > units_q) begin
          if (!fit_mode_q) begin
            pick_d    = idx_q;
            best_d    = r_size;
            found_d   = 1'b1;
            visited_d = 8'(idx_q + 1'b1);
            idx_d     = count_q;
            state_d   = S_MRD;
          end else if (!found_q || r_size < best_q) begin
            pick_d  = idx_q;
            best_d  = r_size;
            found_d = 1'b1;
          end
        end
      end
      S_MRD: begin
        // move entry idx-1 to idx, down to pick+1
        if (idx_q == pick_q + 1'b1) begin
          state_d = S_PWR;
        end else begin
          addr    = AW'(idx_q - 1'b1);
          state_d = S_MWR;
        end
      end
      S_MWR: begin
        we      = 1'b1;
        wdata   = rdata;
        idx_d   = idx_q - 1'b1;
        state_d = S_MRD;
      end
      S_PWR: begin
        // free remainder after the pick, then the allocated front
        we      = 1'b1;
        wdata   = {8'(best_q - units_q), IdWidth'(0), 1'b1};
        idx_d   = pick_q;
        state_d = S_PRD;
      end
      S_PRD: begin
        we      = 1'b1;
        wdata   = {units_q, owner_q, 1'b0};
        count_d = count_q + 1'b1;
        idx_d   = '0;
        state_d = S_CRD;
      end
      S_CRD: begin
        state_d = (idx_q == count_q) ? S_OUT : S_CCHK;
      end
      S_CCHK: begin
        if (r_free && (r_size == 8'd1 || r_size == 8'd2)) small_d = small_q + 1'b1;
        idx_d   = idx_q + 1'b1;
        state_d = S_CRD;
      end
      S_OUT: begin
        if (m_axis_tready) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_INIT;
      fit_mode_q <= 1'b0;
      count_q    <= CW'(1);
      idx_q      <= '0;
      found_q    <= 1'b0;
    end else begin
      if (cfg_wr) fit_mode_q <= pwdata[0];
      state_q <= state_d;
      count_q <= count_d;
      idx_q   <= idx_d;
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pick_q    <= pick_d;
    best_q    <= best_d;
    small_q   <= small_d;
    visited_q <= visited_d;
    status_q  <= status_d;
    if (state_q == S_IDLE && s_axis_tvalid) begin
      op_q    <= s_axis_tdata[0];
      owner_q <= s_axis_tdata[IdWidth:1];
      units_q <= s_axis_tdata[IdWidth+8:IdWidth+1];
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("ready while result pending");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != '0 && count_q <= CW'(MAX_SEGMENTS))
    else $error("segment count out of range");
endmodule

@@ sv/sa_ram.sv @@
// generic single port ram with registered read
// no dependencies
module sa_ram #(
  parameter int Width = 8,
  parameter int Depth = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

@@ dv/segment_allocator_first_best_fit_tb.sv @@
// self-checking testbench for the segment allocator, first and best fit
// depends on sa_pkg and segment_allocator_first_best_fit
module segment_allocator_first_best_fit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sa_pkg::*;

  localparam int StallLimit = 20000;  // cycles with no beat before giving up
  localparam int HoldOff    = 400;    // long receiver hold-off

  typedef struct {
    status_e    status;
    logic [7:0] visited;
    logic [7:0] frags;
  } outcome_t;

  logic        clk_i, rst_ni;
  logic [31:0] s_axis_tdata;
  logic        s_axis_tvalid, s_axis_tready;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tvalid, m_axis_tready;
  logic        psel, penable, pwrite;
  logic [1:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;

  segment_allocator_first_best_fit i_dut (
    .clk_i, .rst_ni,
    .s_axis_tdata, .s_axis_tvalid, .s_axis_tready,
    .m_axis_tdata, .m_axis_tvalid, .m_axis_tready,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  // shadow copy of the segment table
  logic [7:0]  seg_size  [MaxSegments];
  logic [15:0] seg_owner [MaxSegments];
  bit          seg_free  [MaxSegments];
  int          seg_count;
  bit          best_fit;
  int          peak_count;

  logic [31:0] pending_reqs[$];   // request beats not yet offered
  outcome_t    expected_results[$];

  bit calm;                 // no idling on either side
  bit stall_trig, stall_done;
  int stall_left;
  int errors, requests_sent, results_seen, quiet_cycles;

  // predictor: serve one request on the shadow table
  function automatic outcome_t serve_request(logic op, logic [15:0] owner,
                                             logic [7:0] units);
    outcome_t r;
    int pick, i, j, n;
    bit found;
    r.status  = ST_OK;
    r.visited = '0;
    found = 0;
    pick  = 0;
    if (op == OP_ALLOC) begin
      if (units != 0 && seg_count < MaxSegments) begin
        for (i = 0; i < seg_count; i++) begin
          if (seg_free[i] && seg_size[i] > units) begin
            if (!best_fit) begin
              // first fit: the earliest match wins, visited counts up to it
              if (!found) begin
                pick = i;
                found = 1;
                r.visited = 8'(i + 1);
              end
            end else if (!found || seg_size[i] < seg_size[pick]) begin
              pick = i;
              found = 1;
            end
          end
        end
        if (found && best_fit) r.visited = 8'(seg_count);
      end
      if (found) begin
        // open a slot after the chosen segment for the free remainder
        for (j = seg_count; j > pick + 1; j--) begin
          seg_size[j]  = seg_size[j-1];
          seg_owner[j] = seg_owner[j-1];
          seg_free[j]  = seg_free[j-1];
        end
        seg_size[pick+1]  = seg_size[pick] - units;
        seg_owner[pick+1] = '0;
        seg_free[pick+1]  = 1;
        seg_size[pick]    = units;
        seg_owner[pick]   = owner;
        seg_free[pick]    = 0;
        seg_count++;
        if (seg_count > peak_count) peak_count = seg_count;
      end else begin
        r.status  = ST_DECLINED;
        r.visited = '0;
      end
    end else begin
      // free: first allocated segment of that owner, no merging
      r.status = ST_NO_OWNER;
      for (i = 0; i < seg_count; i++) begin
        if (!seg_free[i] && seg_owner[i] == owner) begin
          seg_free[i] = 1;
          r.status = ST_OK;
          break;
        end
      end
    end
    n = 0;
    for (i = 0; i < seg_count; i++)
      if (seg_free[i] && (seg_size[i] == 1 || seg_size[i] == 2)) n++;
    r.frags = 8'(n);
    return r;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (pending_reqs.size() > 0 && (calm || $urandom_range(99) >= 29)) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pending_reqs.pop_front();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // result receiver, with one long hold-off on request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (stall_trig && !stall_done) begin
        stall_left = HoldOff;
        stall_done = 1;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= calm || ($urandom_range(99) >= 29);
      end
    end
  end

  // monitor: predict on each request beat, check each result beat
  always @(posedge clk_i) begin
    outcome_t exp_r;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $display("%0t: result beat with nothing expected, actual %h", $time,
                   m_axis_tdata);
          errors++;
        end else begin
          exp_r = expected_results.pop_front();
          if (m_axis_tdata[1:0] != exp_r.status) begin
            $display("%0t: status expected %0d actual %0d", $time, exp_r.status,
                     m_axis_tdata[1:0]);
            errors++;
          end
          if (m_axis_tdata[9:2] != exp_r.visited) begin
            $display("%0t: visited_count expected %0d actual %0d", $time,
                     exp_r.visited, m_axis_tdata[9:2]);
            errors++;
          end
          if (m_axis_tdata[17:10] != exp_r.frags) begin
            $display("%0t: small_fragments expected %0d actual %0d", $time,
                     exp_r.frags, m_axis_tdata[17:10]);
            errors++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        requests_sent++;
        expected_results.push_back(serve_request(s_axis_tdata[0], s_axis_tdata[16:1],
                                                 s_axis_tdata[24:17]));
      end
    end
  end

  // watchdog on beats
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > StallLimit) begin
      $display("%0t: no beat for %0d cycles", $time, quiet_cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic push_req(logic op, logic [15:0] owner, logic [7:0] units);
    pending_reqs.push_back({7'b0, units, owner, op});
  endtask

  // wait until every request is taken and every result has arrived
  task automatic drain();
    while (pending_reqs.size() > 0 || s_axis_tvalid || expected_results.size() > 0)
      @(posedge clk_i);
  endtask

  task automatic write_fit_mode(bit mode);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_FIT_MODE;
    pwdata  <= {31'b0, mode};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    best_fit = mode;
  endtask

  // random traffic: mostly small allocations and frees of known owners
  task automatic random_phase(int count);
    logic [15:0] owner;
    logic [7:0]  units;
    int k;
    for (k = 0; k < count; k++) begin
      owner = ($urandom_range(99) < 85) ? 16'($urandom_range(1, 24)) : 16'($urandom);
      if ($urandom_range(99) < 55) begin
        case ($urandom_range(9))
          0:       units = 8'($urandom_range(0, 255));
          1:       units = 8'($urandom_range(16, 128));
          default: units = 8'($urandom_range(1, 8));
        endcase
        push_req(OP_ALLOC, owner, units);
      end else begin
        push_req(OP_FREE, owner, 8'($urandom));
      end
    end
  endtask

  initial begin
    int k;
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    calm = 0;
    stall_trig = 0;
    stall_done = 0;
    errors = 0;
    requests_sent = 0;
    results_seen = 0;
    quiet_cycles = 0;
    // table after reset: one free segment of all units
    foreach (seg_size[i]) begin
      seg_size[i] = '0;
      seg_owner[i] = '0;
      seg_free[i] = 0;
    end
    seg_size[0] = 8'(TotalUnits);
    seg_free[0] = 1;
    seg_count = 1;
    peak_count = 1;
    best_fit = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: first fit, field extremes and the corner cases
    write_fit_mode(1'b0);
    push_req(OP_ALLOC, 16'h0001, 8'd0);    // zero request declined
    push_req(OP_ALLOC, 16'h0001, 8'd128);  // equal size is not enough
    push_req(OP_ALLOC, 16'h0001, 8'd255);
    push_req(OP_FREE,  16'h1234, 8'hff);   // no owner
    push_req(OP_ALLOC, 16'hffff, 8'd127);  // leaves a single free unit
    push_req(OP_ALLOC, 16'h0000, 8'd1);    // one unit is not strictly larger
    push_req(OP_FREE,  16'hffff, 8'd0);
    push_req(OP_ALLOC, 16'h0000, 8'd1);    // owner zero like any other
    push_req(OP_ALLOC, 16'h5555, 8'd2);
    push_req(OP_ALLOC, 16'haaaa, 8'd100);
    push_req(OP_FREE,  16'h0000, 8'd0);
    push_req(OP_FREE,  16'h0000, 8'd0);    // already freed
    push_req(OP_ALLOC, 16'h0002, 8'd64);
    push_req(OP_FREE,  16'h5555, 8'd0);
    push_req(OP_FREE,  16'haaaa, 8'd0);
    drain();
    // best fit over the fragmented table
    write_fit_mode(1'b1);
    push_req(OP_ALLOC, 16'h0003, 8'd1);
    push_req(OP_ALLOC, 16'h0004, 8'd50);
    push_req(OP_ALLOC, 16'h0005, 8'd3);
    push_req(OP_ALLOC, 16'h0006, 8'd200);
    push_req(OP_FREE,  16'h0004, 8'd0);
    push_req(OP_ALLOC, 16'h0007, 8'd10);
    drain();

    // random, best fit
    random_phase(440);
    drain();
    // random, first fit, with a long receiver hold-off mid phase
    write_fit_mode(1'b0);
    random_phase(440);
    wait (requests_sent > 500);
    stall_trig = 1;
    drain();
    // random, best fit, no idling at all
    write_fit_mode(1'b1);
    calm = 1;
    random_phase(440);
    drain();
    calm = 0;
    // random, first fit, then try to fill the table
    write_fit_mode(1'b0);
    random_phase(440);
    drain();
    for (k = 0; k < 140 && seg_count < MaxSegments; k++) begin
      push_req(OP_ALLOC, 16'($urandom_range(1, 24)), 8'd1);
      drain();
    end
    push_req(OP_ALLOC, 16'h0009, 8'd1);    // declined when the table is full
    push_req(OP_FREE,  16'h0001, 8'd0);
    push_req(OP_ALLOC, 16'h0009, 8'd1);
    drain();

    repeat (1000) @(posedge clk_i);
    $display("%0d requests and %0d results checked in both fit modes", requests_sent,
             results_seen);
    $display("segment table peaked at %0d of %0d entries", peak_count, MaxSegments);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
sv/sa_pkg.sv
sv/sa_ram.sv
sv/segment_allocator_first_best_fit.sv
dv/segment_allocator_first_best_fit_tb.sv
